[design/bntd_pkg.sv]
// ----------------------------------------------------------------------------
// bntd_pkg
// Shared types, codes and helper functions for the base-N text decoder.
// ----------------------------------------------------------------------------
package bntd_pkg;

  localparam int CharW    = 8;
  localparam int ByteW    = 8;
  localparam int StatusW  = 3;
  localparam int ModeW    = 2;
  localparam int SymW     = 6;
  localparam int AccW     = 13;
  localparam int HeldW    = 4;
  localparam int PadCntW  = 3;
  localparam int ChunkW   = 3;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Alphabet select codes
  localparam logic [ModeW-1:0] MODE_B64  = 2'd0;
  localparam logic [ModeW-1:0] MODE_B32H = 2'd1;
  localparam logic [ModeW-1:0] MODE_B16  = 2'd2;

  // Register index of the mode register
  localparam logic REG_MODE = 1'b0;

  // End-of-text status codes
  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_BAD_CHAR  = 3'd1;
  localparam logic [StatusW-1:0] ST_PAD_MANY  = 3'd2;
  localparam logic [StatusW-1:0] ST_PAD_COUNT = 3'd3;
  localparam logic [StatusW-1:0] ST_PAD_BITS  = 3'd4;

  localparam logic [CharW-1:0] CHAR_PAD = 8'h3D;

  typedef enum logic [1:0] {
    CLS_BLANK,
    CLS_PAD,
    CLS_SYM,
    CLS_BAD
  } sym_class_t;

  // One classified character on its way from front to back
  typedef struct packed {
    sym_class_t          cls;
    logic [SymW-1:0]     value;
    logic                end_of_text;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [ChunkW-1:0] chunk_bits(input logic [ModeW-1:0] mode);
    logic [ChunkW-1:0] b;
    case (mode)
      MODE_B64:  b = 3'd6;
      MODE_B32H: b = 3'd5;
      default:   b = 3'd4;
    endcase
    return b;
  endfunction

  function automatic logic [PadCntW-1:0] pad_limit(input logic [ModeW-1:0] mode);
    logic [PadCntW-1:0] lim;
    case (mode)
      MODE_B64:  lim = 3'd2;
      MODE_B32H: lim = 3'd6;
      default:   lim = 3'd0;
    endcase
    return lim;
  endfunction

  // True when p pads round up to more pad bits than one more chunk would hold
  function automatic logic bad_pad_count(input logic [ModeW-1:0]   mode,
                                         input logic [PadCntW-1:0] p);
    logic [ChunkW-1:0] b;
    logic [6:0]        prod;
    logic [6:0]        padbits;
    logic [6:0]        room;
    b       = chunk_bits(mode);
    prod    = 7'(p) * 7'(b);
    padbits = (prod + 7'd7) & 7'b1111000;
    room    = 7'(b) * (7'(p) + 7'd1);
    return padbits > room;
  endfunction

endpackage

[design/bntd_ifs.sv]
// ----------------------------------------------------------------------------
// bntd_ifs
// Valid/ready channels for text characters and decoded results.
// ----------------------------------------------------------------------------
interface bntd_char_if import bntd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] in_char;
  logic             end_of_text;

  modport source (output valid, in_char, end_of_text, input ready);
  modport sink   (input valid, in_char, end_of_text, output ready);
endinterface

interface bntd_result_if import bntd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   data_byte;
  logic               has_byte;
  logic               is_final;
  logic [StatusW-1:0] status;

  modport source (output valid, data_byte, has_byte, is_final, status, input ready);
  modport sink   (input valid, data_byte, has_byte, is_final, status, output ready);
endinterface

[design/bntd_front.sv]
// ----------------------------------------------------------------------------
// bntd_front
// Accept characters and classify them against the active alphabet.
// ----------------------------------------------------------------------------
module bntd_front import bntd_pkg::*; (
  bntd_char_if.sink         text,
  input  logic [ModeW-1:0]  mode,
  input  logic              queue_full,
  output logic              push,
  output entry_t            entry
);

  logic [CharW-1:0] c;
  logic [CharW-1:0] top;
  logic             blank;

  assign c     = text.in_char;
  assign blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  assign top   = (mode == MODE_B32H) ? 8'd21 : 8'd5;

  assign text.ready = !queue_full;
  assign push       = text.valid && !queue_full;

  always_comb begin
    entry.end_of_text = text.end_of_text;
    entry.value       = '0;
    entry.cls         = CLS_BAD;
    if (blank) begin
      entry.cls = CLS_BLANK;
    end else if (c == CHAR_PAD) begin
      entry.cls = CLS_PAD;
    end else if (mode == MODE_B64) begin
      if (c >= "A" && c <= "Z") begin
        entry.cls   = CLS_SYM;
        entry.value = SymW'(c - "A");
      end else if (c >= "a" && c <= "z") begin
        entry.cls   = CLS_SYM;
        entry.value = SymW'(c - "a" + 8'd26);
      end else if (c >= "0" && c <= "9") begin
        entry.cls   = CLS_SYM;
        entry.value = SymW'(c - "0" + 8'd52);
      end else if (c == "+") begin
        entry.cls   = CLS_SYM;
        entry.value = 6'd62;
      end else if (c == "/") begin
        entry.cls   = CLS_SYM;
        entry.value = 6'd63;
      end
    end else begin
      if (c >= "0" && c <= "9") begin
        entry.cls   = CLS_SYM;
        entry.value = SymW'(c - "0");
      end else if (c >= "A" && c <= 8'("A") + top) begin
        entry.cls   = CLS_SYM;
        entry.value = SymW'(c - "A" + 8'd10);
      end else if (c >= "a" && c <= 8'("a") + top) begin
        entry.cls   = CLS_SYM;
        entry.value = SymW'(c - "a" + 8'd10);
      end
    end
  end

endmodule

[design/bntd_queue.sv]
// ----------------------------------------------------------------------------
// bntd_queue
// Short FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module bntd_queue import bntd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  entry_t      push_entry,
  input  logic        pop,
  output entry_t      head,
  output queue_stat_t stat
);

  entry_t                slots [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr;
  logic [QueuePtrW-1:0]  rd_ptr;
  logic [QueueCntW-1:0]  count;

  assign stat.full  = (count == QueueCntW'(QueueDepth));
  assign stat.empty = (count == '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/bntd_back.sv]
// ----------------------------------------------------------------------------
// bntd_back
// Bit accumulator, pad and error tracking, and the result register.
// ----------------------------------------------------------------------------
module bntd_back import bntd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [ModeW-1:0]  mode,
  input  entry_t            head,
  input  logic              queue_empty,
  output logic              pop,
  bntd_result_if.source     decoded
);

  logic [AccW-1:0]    acc;
  logic [HeldW-1:0]   held;
  logic [PadCntW-1:0] pads;
  logic               in_padding;
  logic [StatusW-1:0] error_code;

  logic [AccW-1:0]    acc_next;
  logic [HeldW-1:0]   held_next;
  logic [PadCntW-1:0] pads_next;
  logic               in_padding_next;
  logic [StatusW-1:0] error_next;

  logic [ChunkW-1:0]  b;
  logic [AccW-1:0]    acc_shift;
  logic [HeldW-1:0]   held_sum;
  logic [2:0]         held_rem;
  logic               got;
  logic [ByteW-1:0]   byte_val;
  logic [StatusW-1:0] status_val;
  logic [AccW-1:0]    left_mask;

  logic               out_valid;
  logic [ByteW-1:0]   out_byte;
  logic               out_has;
  logic               out_final;
  logic [StatusW-1:0] out_status;

  assign b   = chunk_bits(mode);
  assign pop = !queue_empty && (!out_valid || decoded.ready);

  always_comb begin
    acc_next        = acc;
    held_next       = held;
    pads_next       = pads;
    in_padding_next = in_padding;
    error_next      = error_code;
    got             = 1'b0;
    byte_val        = '0;
    acc_shift       = (acc << b) | AccW'(head.value);
    held_sum        = held + HeldW'(b);
    held_rem        = held_sum[2:0];
    case (head.cls)
      CLS_PAD: begin
        in_padding_next = 1'b1;
        if (pads != 3'd7) begin
          pads_next = pads + 1'b1;
        end
        if (pads_next > pad_limit(mode) && error_code == ST_OK) begin
          error_next = ST_PAD_MANY;
        end
      end
      CLS_SYM, CLS_BAD: begin
        if (head.cls == CLS_BAD || in_padding) begin
          if (error_code == ST_OK) begin
            error_next = ST_BAD_CHAR;
          end
        end else if (error_code == ST_OK) begin
          acc_next  = acc_shift;
          held_next = held_sum;
          if (held_sum >= 4'd8) begin
            // held_sum - 8 is its low three bits
            held_next = HeldW'(held_rem);
            byte_val  = ByteW'(acc_shift >> held_rem);
            acc_next  = acc_shift & ((AccW'(1) << held_rem) - AccW'(1));
            got       = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    left_mask  = (AccW'(1) << held_next) - AccW'(1);
    status_val = error_next;
    if (error_next == ST_OK) begin
      if (bad_pad_count(mode, pads_next)) begin
        status_val = ST_PAD_COUNT;
      end else if ((acc_next & left_mask) != '0) begin
        status_val = ST_PAD_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      held       <= '0;
      pads       <= '0;
      in_padding <= 1'b0;
      error_code <= ST_OK;
    end else if (pop) begin
      if (head.end_of_text) begin
        acc        <= '0;
        held       <= '0;
        pads       <= '0;
        in_padding <= 1'b0;
        error_code <= ST_OK;
      end else begin
        acc        <= acc_next;
        held       <= held_next;
        pads       <= pads_next;
        in_padding <= in_padding_next;
        error_code <= error_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= got || head.end_of_text;
    end else if (decoded.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte   <= byte_val;
      out_has    <= got;
      out_final  <= head.end_of_text;
      out_status <= head.end_of_text ? status_val : ST_OK;
    end
  end

  assign decoded.valid     = out_valid;
  assign decoded.data_byte = out_byte;
  assign decoded.has_byte  = out_has;
  assign decoded.is_final  = out_final;
  assign decoded.status    = out_status;

endmodule

[design/base_n_text_decoder.sv]
// ----------------------------------------------------------------------------
// base_n_text_decoder
// RFC 4648 text decoder (base64, base32hex, base16), one character a beat.
// ----------------------------------------------------------------------------
//
//  channel  | dir | beat carries                           | handshake
//  ---------+-----+----------------------------------------+-------------
//  text     | in  | in_char, end_of_text                   | valid/ready
//  decoded  | out | data_byte, has_byte, is_final, status  | valid/ready
//  apb      | in  | alphabet_mode at byte address 0        | psel/penable
//
//  One character enters per cycle while the queue has room; the front classifies
//  each taken character into the queue, and the back pops it from there,
//  updating the accumulator and loading the result register that drives the
//  decoded beat.
//  Reset (rst, synchronous) empties the queue, clears decode state and
//  returns alphabet_mode to base64.
//  A stalled result holds in the result register; the 4-entry queue soaks up
//  characters meanwhile, and text.ready drops once it fills.
//  Characters that make no byte (whitespace, pads, partial symbols) give no
//  beat unless they carry end_of_text.
// ----------------------------------------------------------------------------
module base_n_text_decoder import bntd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  bntd_char_if.sink            text,
  bntd_result_if.source        decoded,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ApbAddrW-1:0]  paddr,
  input  logic [ApbDataW-1:0]  pwdata,
  output logic [ApbDataW-1:0]  prdata,
  output logic                 pready
);

  logic [ModeW-1:0] alphabet_mode;
  logic             push;
  logic             pop;
  entry_t           push_entry;
  entry_t           head;
  queue_stat_t      qstat;

  // Configuration: single register, zero-wait APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? ApbDataW'(alphabet_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_mode <= MODE_B64;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MODE) begin
      alphabet_mode <= pwdata[ModeW-1:0];
    end
  end

  // Front: classify each character and push it into the queue
  bntd_front u_front (
    .text       (text),
    .mode       (alphabet_mode),
    .queue_full (qstat.full),
    .push       (push),
    .entry      (push_entry)
  );

  // Queue decouples acceptance from the result side
  bntd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (qstat)
  );

  // Back: accumulate bits, track pads and errors, drive the result beat
  bntd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .mode        (alphabet_mode),
    .head        (head),
    .queue_empty (qstat.empty),
    .pop         (pop),
    .decoded     (decoded)
  );

  // A beat that does not end the text always carries a byte
  a_nonfinal_has_byte: assert property (@(posedge clk) disable iff (rst)
    decoded.valid && !decoded.is_final |-> decoded.has_byte)
    else $error("non-final beat without a byte");

  // Status is only reported on the final beat
  a_status_final_only: assert property (@(posedge clk) disable iff (rst)
    decoded.valid && !decoded.is_final |-> decoded.status == ST_OK)
    else $error("status set on a non-final beat");

  // Status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    decoded.valid |-> decoded.status <= ST_PAD_BITS)
    else $error("status code out of range");

  // Queue never reports full and empty together, nor pops when empty
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty) && !(pop && qstat.empty))
    else $error("queue state inconsistent");

endmodule

[tb/tb_base_n_text_decoder.sv]
// ----------------------------------------------------------------------------
// tb_base_n_text_decoder
// Self-checking bench for the base-N text decoder. Character beats go in on
// the text channel. Each accepted beat is run through a local decode model
// that keeps its own accumulator, pad count and sticky error. Every decoded
// beat is then checked field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_base_n_text_decoder import bntd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DrainCycles = 12;    // queue depth plus pipe latency, with margin
  localparam int unsigned IdleLimit   = 4000;  // cycles with no beat before giving up
  localparam int unsigned AccMask     = 32'h1FFF;
  localparam int unsigned PadSat      = 7;

  // Two-bit mode value with no name of its own; decodes as base16
  localparam logic [ModeW-1:0]    MODE_B16_ALIAS = 2'd3;
  localparam logic [ApbAddrW-1:0] MODE_ADDR      = ApbAddrW'(4 * REG_MODE);

  localparam logic [CharW-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CharW-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CharW-1:0] CH_ZERO    = 8'h30;
  localparam logic [CharW-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CharW-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CharW-1:0] CH_SPACE   = 8'h20;
  localparam logic [CharW-1:0] CH_TAB     = 8'h09;
  localparam logic [CharW-1:0] CH_CR      = 8'h0D;

  typedef struct packed {
    logic [ByteW-1:0]   data_byte;
    logic               has_byte;
    logic               is_final;
    logic [StatusW-1:0] status;
  } beat_t;

  typedef logic [CharW-1:0] char_q_t[$];

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  bntd_char_if   text_ch ();
  bntd_result_if result_ch ();

  base_n_text_decoder u_top (
    .clk     (clk),
    .rst     (rst),
    .text    (text_ch),
    .decoded (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Decode model state, a private copy kept in step with the block
  logic [ModeW-1:0]   alphabet_q = MODE_B64;
  int unsigned        acc_bits   = 0;
  int unsigned        bits_held  = 0;
  int unsigned        pad_count  = 0;
  bit                 in_pad     = 1'b0;
  logic [StatusW-1:0] first_err  = ST_OK;

  beat_t       expected_beats[$];
  int unsigned mismatches = 0;
  int unsigned chars_sent = 0;
  int unsigned texts_sent = 0;
  int unsigned beats_seen = 0;
  int unsigned finals_by_status[8];
  bit          gaps_on    = 1'b1;
  bit          stalls_on  = 1'b1;

  // --------------------------------------------------------------------------
  // Alphabet helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned chunk_width(input logic [ModeW-1:0] mode);
    if (mode == MODE_B64) return 6;
    if (mode == MODE_B32H) return 5;
    return 4;
  endfunction

  function automatic int unsigned pad_limit_of(input logic [ModeW-1:0] mode);
    if (mode == MODE_B64) return 2;
    if (mode == MODE_B32H) return 6;
    return 0;
  endfunction

  function automatic bit is_blank(input logic [CharW-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Symbol value of c, or 64 when c is outside the active alphabet
  function automatic int unsigned symbol_of(input logic [CharW-1:0] c,
                                            input logic [ModeW-1:0] mode);
    int unsigned top;
    if (mode == MODE_B64) begin
      if (c >= CH_UPPER_A && c <= CH_UPPER_A + 25) return c - CH_UPPER_A;
      if (c >= CH_LOWER_A && c <= CH_LOWER_A + 25) return c - CH_LOWER_A + 26;
      if (c >= CH_ZERO && c <= CH_ZERO + 9) return c - CH_ZERO + 52;
      if (c == CH_PLUS) return 62;
      if (c == CH_SLASH) return 63;
      return 64;
    end
    top = (mode == MODE_B32H) ? 21 : 5;
    if (c >= CH_ZERO && c <= CH_ZERO + 9) return c - CH_ZERO;
    if (c >= CH_UPPER_A && c <= CH_UPPER_A + top) return c - CH_UPPER_A + 10;
    if (c >= CH_LOWER_A && c <= CH_LOWER_A + top) return c - CH_LOWER_A + 10;
    return 64;
  endfunction

  // Character for symbol value v; lower picks the case of hex letters
  function automatic logic [CharW-1:0] symbol_char(input int unsigned v,
                                                   input logic [ModeW-1:0] mode,
                                                   input bit lower);
    if (mode == MODE_B64) begin
      if (v < 26) return CharW'(CH_UPPER_A + v);
      if (v < 52) return CharW'(CH_LOWER_A + v - 26);
      if (v < 62) return CharW'(CH_ZERO + v - 52);
      return (v == 62) ? CH_PLUS : CH_SLASH;
    end
    if (v < 10) return CharW'(CH_ZERO + v);
    return CharW'((lower ? CH_LOWER_A : CH_UPPER_A) + v - 10);
  endfunction

  function automatic logic [CharW-1:0] blank_char();
    int unsigned pick;
    pick = $urandom_range(0, 5);
    return (pick == 0) ? CH_SPACE : CharW'(CH_TAB + pick - 1);
  endfunction

  // Mostly short idles, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic char_q_t text_of(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Well-formed encoding of a few random bytes, blanks sprinkled in,
  // padded to a full group most of the time
  function automatic char_q_t encode_random(input logic [ModeW-1:0] mode);
    char_q_t     q;
    int unsigned b, acc, held, nsyms, group, npads;
    b     = chunk_width(mode);
    group = (mode == MODE_B64) ? 4 : (mode == MODE_B32H) ? 8 : 1;
    acc   = 0;
    held  = 0;
    nsyms = 0;
    repeat ($urandom_range(0, 9)) begin
      acc  = (acc << 8) | $urandom_range(0, 255);
      held += 8;
      while (held >= b) begin
        held -= b;
        if ($urandom_range(0, 9) == 0) q.push_back(blank_char());
        q.push_back(symbol_char((acc >> held) & ((1 << b) - 1), mode, $urandom_range(0, 1)));
        acc &= (1 << held) - 1;
        nsyms++;
      end
    end
    if (held != 0) begin
      q.push_back(symbol_char((acc << (b - held)) & ((1 << b) - 1), mode,
                              $urandom_range(0, 1)));
      nsyms++;
    end
    npads = (group - nsyms % group) % group;
    if ($urandom_range(0, 9) == 0) npads = 0;
    repeat (npads) begin
      if ($urandom_range(0, 9) == 0) q.push_back(blank_char());
      q.push_back(CHAR_PAD);
    end
    if ($urandom_range(0, 3) == 0 || q.size() == 0) q.push_back(blank_char());
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Decode model: one character in, at most one beat out
  // --------------------------------------------------------------------------
  function automatic bit decode_char(input logic [CharW-1:0] c, input logic eot,
                                     output beat_t r);
    int unsigned        b, v, room;
    bit                 got;
    logic [ByteW-1:0]   dec;
    logic [StatusW-1:0] st;
    b   = chunk_width(alphabet_q);
    got = 1'b0;
    dec = '0;
    if (is_blank(c)) begin
      // blanks are dropped wherever they stand
    end else if (c == CHAR_PAD) begin
      in_pad = 1'b1;
      if (pad_count < PadSat) pad_count++;
      if (pad_count > pad_limit_of(alphabet_q) && first_err == ST_OK) first_err = ST_PAD_MANY;
    end else begin
      v = symbol_of(c, alphabet_q);
      if (v > 63 || in_pad) begin
        if (first_err == ST_OK) first_err = ST_BAD_CHAR;
      end else if (first_err == ST_OK) begin
        acc_bits  = ((acc_bits << b) | v) & AccMask;
        bits_held += b;
        if (bits_held >= 8) begin
          bits_held -= 8;
          dec       = ByteW'(acc_bits >> bits_held);
          acc_bits  &= (1 << bits_held) - 1;
          got       = 1'b1;
        end
      end
    end
    r.data_byte = dec;
    r.has_byte  = got;
    r.is_final  = eot;
    r.status    = ST_OK;
    if (!eot) return got;
    // End of text: sticky error first, then pad count, then leftover bits
    st = first_err;
    if (st == ST_OK) begin
      room = b * (pad_count + 1);
      if (((pad_count * b + 7) & ~32'd7) > room) st = ST_PAD_COUNT;
      else if ((acc_bits & ((1 << bits_held) - 1)) != 0) st = ST_PAD_BITS;
    end
    r.status  = st;
    acc_bits  = 0;
    bits_held = 0;
    pad_count = 0;
    in_pad    = 1'b0;
    first_err = ST_OK;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Clock: 4 ns period
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result sink: toggle ready at falling edges. Long stalls back the text
  // channel up through the block's queue.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold;
    hold            = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        result_ch.ready <= 1'b0;
        hold--;
      end else begin
        result_ch.ready <= 1'b1;
        if (stalls_on && $urandom_range(0, 99) < 20) hold = idle_len();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Beat checker: pop the oldest expectation on every accepted beat and
  // compare each field on its own
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : beat_check
    beat_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      beats_seen++;
      if (result_ch.is_final) finals_by_status[result_ch.status]++;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte=%02h has=%b final=%b status=%0d",
                                  result_ch.data_byte, result_ch.has_byte,
                                  result_ch.is_final, result_ch.status));
      end else begin
        want = expected_beats.pop_front();
        if (result_ch.data_byte !== want.data_byte)
          report_mismatch($sformatf("beat %0d data_byte %02h, want %02h", beats_seen,
                                    result_ch.data_byte, want.data_byte));
        if (result_ch.has_byte !== want.has_byte)
          report_mismatch($sformatf("beat %0d has_byte %b, want %b", beats_seen,
                                    result_ch.has_byte, want.has_byte));
        if (result_ch.is_final !== want.is_final)
          report_mismatch($sformatf("beat %0d is_final %b, want %b", beats_seen,
                                    result_ch.is_final, want.is_final));
        if (result_ch.status !== want.status)
          report_mismatch($sformatf("beat %0d status %0d, want %0d", beats_seen,
                                    result_ch.status, want.status));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles in which no beat moves on any port
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if (rst || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)
          || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] watchdog: nothing moved for %0d cycles", $time, IdleLimit);
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Text source and register access
  // --------------------------------------------------------------------------

  // Drive one character, hold it until taken, then predict its beat
  task automatic send_char(input logic [CharW-1:0] c, input logic eot);
    int unsigned gap;
    beat_t       r;
    gap = (gaps_on && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      text_ch.valid <= 1'b0;
    end
    @(negedge clk);
    text_ch.valid       <= 1'b1;
    text_ch.in_char     <= c;
    text_ch.end_of_text <= eot;
    do @(posedge clk); while (!text_ch.ready);
    chars_sent++;
    if (decode_char(c, eot, r)) expected_beats.push_back(r);
  endtask

  // Send a whole text; the last character carries end_of_text
  task automatic send_text(input char_q_t q);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
    texts_sent++;
  endtask

  // Drop valid, wait out every expected beat, then let blank and pad
  // characters still in the queue drain through
  task automatic wait_drained();
    @(negedge clk);
    text_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready
  task automatic apb_access(input bit wr, input logic [ApbDataW-1:0] wdata,
                            output logic [ApbDataW-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MODE_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Switch alphabets only with the block idle; junk in the upper bits of
  // the write data must be ignored, and the read-back must match
  task automatic set_alphabet(input logic [ModeW-1:0] mode);
    logic [ApbDataW-1:0] wdata;
    logic [ApbDataW-1:0] rd;
    wait_drained();
    wdata              = $urandom();
    wdata[ModeW-1:0]   = mode;
    apb_access(1'b1, wdata, rd);
    alphabet_q = mode;
    apb_access(1'b0, '0, rd);
    if (rd[ModeW-1:0] !== mode)
      report_mismatch($sformatf("alphabet_mode reads %0d, want %0d", rd[ModeW-1:0], mode));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Base64 after reset: leading blank, clean padding, leftover bits, a sticky
  // bad character with the byte extremes, a symbol after a pad, too many pads
  task automatic test_base64_directed();
    logic [ApbDataW-1:0] rd;
    char_q_t             q;
    apb_access(1'b0, '0, rd);
    if (rd[ModeW-1:0] !== MODE_B64)
      report_mismatch($sformatf("alphabet_mode after reset reads %0d", rd[ModeW-1:0]));
    send_text(text_of(" TQ=="));
    send_text(text_of("TR="));
    q = text_of("TQ");
    q.push_front(8'h00);
    q.push_back(8'hFF);
    send_text(q);
    send_text(text_of("T=A"));
    send_text(text_of("==="));
  endtask

  // Base32hex: two pads round past one more chunk; lower and upper case
  // top symbols leave nonzero bits behind
  task automatic test_base32hex_directed();
    set_alphabet(MODE_B32H);
    send_text(text_of("0=="));
    send_text(text_of("vV"));
  endtask

  // Base16 and the unnamed fourth setting, which must act as base16
  task automatic test_base16_directed();
    set_alphabet(MODE_B16);
    send_text(text_of("fF"));
    set_alphabet(MODE_B16_ALIAS);
    send_text(text_of("A="));
  endtask

  // Random texts: mostly well-formed, some with one character corrupted,
  // some junk, and a few long pad runs, most of which saturate the pad count
  task automatic test_random_decode(input logic [ModeW-1:0] mode, input int unsigned n_chars,
                                    input bit with_gaps, input bit with_stalls,
                                    input bit with_pauses);
    char_q_t     q;
    int unsigned start, pick, n_texts, b;
    set_alphabet(mode);
    gaps_on   = with_gaps;
    stalls_on = with_stalls;
    b         = chunk_width(mode);
    start     = chars_sent;
    n_texts   = 0;
    while (chars_sent - start < n_chars) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        q = encode_random(mode);
      end else if (pick < 75) begin
        q = encode_random(mode);
        q[$urandom_range(0, q.size() - 1)] = CharW'($urandom_range(0, 255));
      end else if (pick < 95) begin
        q.delete();
        repeat ($urandom_range(1, 10)) begin
          pick = $urandom_range(0, 99);
          if (pick < 30) q.push_back(CharW'($urandom_range(0, 255)));
          else if (pick < 70)
            q.push_back(symbol_char($urandom_range(0, (1 << b) - 1), mode,
                                    $urandom_range(0, 1)));
          else if (pick < 85) q.push_back(CHAR_PAD);
          else q.push_back(blank_char());
        end
      end else begin
        q.delete();
        if ($urandom_range(0, 1)) q.push_back(symbol_char(0, mode, 1'b0));
        repeat ($urandom_range(6, 9)) q.push_back(CHAR_PAD);
      end
      send_text(q);
      n_texts++;
      // hold the sender until the decoder has delivered everything
      if (with_pauses && n_texts % 16 == 0) wait_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    text_ch.valid       = 1'b0;
    text_ch.in_char     = '0;
    text_ch.end_of_text = 1'b0;
    foreach (finals_by_status[i]) finals_by_status[i] = 0;

    // hold reset from time zero, release it on a falling edge
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_base64_directed();
    test_base32hex_directed();
    test_base16_directed();

    test_random_decode(MODE_B64,       350, 1'b1, 1'b1, 1'b1);
    test_random_decode(MODE_B32H,      300, 1'b0, 1'b0, 1'b0);  // full rate, no idling
    test_random_decode(MODE_B16,       250, 1'b1, 1'b1, 1'b0);
    test_random_decode(MODE_B16_ALIAS, 150, 1'b1, 1'b0, 1'b0);
    test_random_decode(MODE_B64,       150, 1'b0, 1'b1, 1'b1);

    wait_drained();
    $display("covered %0d characters in %0d texts over all four alphabet settings, %0d beats",
             chars_sent, texts_sent, beats_seen);
    $display("end-of-text status: ok %0d, bad char %0d, pads %0d, pad count %0d, bits %0d",
             finals_by_status[ST_OK], finals_by_status[ST_BAD_CHAR],
             finals_by_status[ST_PAD_MANY], finals_by_status[ST_PAD_COUNT],
             finals_by_status[ST_PAD_BITS]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
